// File: src/cmg_pkg.sv
`timescale 1ns / 1ps
// cmg_pkg: types, constants and small helper functions of the calendar month grid.
// No dependencies; imported by cmg_cfg and calendar_month_grid_unit.
package cmg_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SW_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SW_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SW_DAY   = 2'd2;

  // legal ranges
  localparam logic [11:0] SW_YEAR_MIN = 12'd1582;
  localparam logic [11:0] SW_YEAR_MAX = 12'd4000;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;

  // first year of the first Gregorian 400-year cycle after the reform
  localparam logic [13:0] GREG_EPOCH  = 14'd1601;
  // days dropped by the reform of 1582
  localparam logic [4:0]  SKIP_BASE   = 5'd10;

  // floor(t / 100) = (t * 5243) >> 19, exact for t below 8400
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned QUOT_W       = 7;
  localparam int unsigned PROD_W       = 27;

  typedef struct packed {
    logic [3:0]  month;
    logic [13:0] year;
  } in_t;

  typedef struct packed {
    logic [4:0] day_number;
    logic [2:0] row;
    logic [2:0] column;
    logic       last;
    logic       error;
  } out_t;

  // switch date after range saturation
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } sw_cfg_t;

  // month length with February as 29; zero for codes that are no month
  function automatic logic [4:0] base_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:                         len = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:           len = 5'd31;
      default:                      len = 5'd0;
    endcase
    return len;
  endfunction

  // x mod 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [13:0] x);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]) + 5'(x[13:12]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    u = 3'(t[3]) + t[2:0];
    return (u == 3'd7) ? 3'd0 : u;
  endfunction

  // sum of two residues mod 7
  function automatic logic [2:0] add7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = 4'(a) + 4'(b);
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

endpackage

// File: src/cmg_cfg.sv
`timescale 1ns / 1ps
// cmg_cfg: switch-date configuration registers and their range saturation.
// Depends on cmg_pkg.
module cmg_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output cmg_pkg::sw_cfg_t                  sw
);
  import cmg_pkg::*;

  // reset values: British reform of 1752
  localparam logic [11:0] RST_SW_YEAR  = 12'd1752;
  localparam logic [3:0]  RST_SW_MONTH = 4'd9;
  localparam logic [4:0]  RST_SW_DAY   = 5'd3;

  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [3:0]  mon_sat;
  logic [4:0]  day_max;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= RST_SW_YEAR;
      month_r <= RST_SW_MONTH;
      day_r   <= RST_SW_DAY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SW_YEAR:  year_r  <= cfg_data[11:0];
        REG_SW_MONTH: month_r <= cfg_data[3:0];
        REG_SW_DAY:   day_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // saturate to legal ranges; day bound follows the saturated month
  always_comb begin
    mon_sat = (month_r == 4'd0) ? 4'd1 : ((month_r > MONTH_MAX) ? MONTH_MAX : month_r);
    day_max = base_len(mon_sat);
    sw.month = mon_sat;
    sw.year  = (year_r < SW_YEAR_MIN) ? SW_YEAR_MIN :
               ((year_r > SW_YEAR_MAX) ? SW_YEAR_MAX : year_r);
    sw.day   = (day_r == 5'd0) ? 5'd1 : ((day_r > day_max) ? day_max : day_r);
  end

endmodule

// File: src/calendar_month_grid_unit.sv
`timescale 1ns / 1ps
// calendar_month_grid_unit: top level, request sequencer and day emitter.
// Depends on cmg_pkg and cmg_cfg.
//
// For each accepted (month, year) request the block emits one transfer per printed
// day: day number, grid row and weekday column (0 is Sunday), with last set on the
// final one. Years up to the switch year are Julian, later years Gregorian; the days
// dropped at the switch are left out, also when they run into the next month or the
// next January. A bad month or year gives a single transfer with error and last set.
// A request passes S_QG and S_QY, which reuse a constant multiplier for the divisions
// by 100, and S_LEN; then one shared mod-7 adder sums the lengths of the months before
// the requested one, one month per cycle, and then steps the weekday column once per
// emitted day. An error request goes straight to S_ERR. Input is stalled for the whole
// request. A fully skipped month gives no transfer at all.
module calendar_month_grid_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cmg_pkg::in_t                      in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output cmg_pkg::out_t                     out_data,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cmg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a request
    S_QG,     // divide switch year offset by 100
    S_QY,     // divide request year offset by 100, skip count
    S_LEN,    // February, overflow, carried skip, Jan 1 weekday
    S_SUM,    // add lengths of earlier months, one per cycle
    S_ADJ,    // skip correction, load emitter
    S_EMIT,   // one day per transfer
    S_ERR     // single error transfer
  } state_t;

  sw_cfg_t     sw;
  state_t      state_r;

  logic [3:0]  m_r;
  logic [13:0] y_r;
  logic [11:0] yg_r;
  logic [3:0]  mg_r;
  logic [4:0]  dg_r;
  logic [QUOT_W-1:0] qg_r, qy_r;
  logic [4:0]  sg_r;
  logic        lg_r, cnq_g_r;
  logic        is_sw_r, is_nx_r, feb29_r, ovf_r;
  logic [4:0]  skip_r;
  logic [2:0]  acc_r;
  logic [3:0]  k_r;
  logic [4:0]  day_r, end_r;
  logic [2:0]  row_r;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    return (mon == 4'd2) ? (5'd28 + 5'(leap)) : base_len(mon);
  endfunction

  cmg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sw        (sw)
  );

  // request check
  logic bad_req;
  assign bad_req = (in_data.month == 4'd0) || (in_data.month > MONTH_MAX) ||
                   (in_data.year == 14'd0) || (in_data.year > YEAR_MAX);

  // shared divide-by-100 multiplier
  logic [13:0]       yg_ext, t_g, t_y, mul_in;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  assign yg_ext = {2'b00, yg_r};
  assign t_g    = (yg_ext >= GREG_EPOCH) ? (yg_ext - GREG_EPOCH) : 14'd0;
  assign t_y    = (y_r >= GREG_EPOCH) ? (y_r - GREG_EPOCH) : 14'd0;
  assign mul_in = (state_r == S_QG) ? t_g : t_y;
  assign prod   = PROD_W'(mul_in) * PROD_W'(DIV100_RECIP);
  assign quot   = prod[DIV100_SHIFT +: QUOT_W];

  // century years that are Julian but not Gregorian leap years
  logic [13:0] r_g, r_y;
  logic        cnq_g, cnq_y;
  assign r_g   = t_g - (14'(qg_r) * 14'd100);
  assign r_y   = t_y - (14'(qy_r) * 14'd100);
  assign cnq_g = (yg_ext >= GREG_EPOCH) && (r_g == 14'd99) && (qg_r[1:0] != 2'd3);
  assign cnq_y = (y_r >= GREG_EPOCH) && (r_y == 14'd99) && (qy_r[1:0] != 2'd3);

  // days dropped at the switch, plus the Julian-only leap day when it lies before it
  logic [4:0] sg_base, sg_nxt;
  logic       lg_nxt;
  assign sg_base = 5'(qg_r - (qg_r >> 2)) + SKIP_BASE;
  assign lg_nxt  = cnq_g && ((mg_r >= 4'd3) ||
                   ((mg_r == 4'd2) && ((6'(dg_r) + 6'(sg_base)) > 6'd28)));
  assign sg_nxt  = sg_base + 5'(lg_nxt);

  // year class, February and carried skip
  logic       is_sw, is_nx, after, feb29_nxt, ovf_nxt;
  logic [4:0] full_mg, skip_nxt;
  logic [5:0] dg_sg;
  assign is_sw   = (y_r == yg_ext);
  assign is_nx   = (y_r == (yg_ext + 14'd1));
  assign after   = (y_r > yg_ext);
  assign dg_sg   = 6'(dg_r) + 6'(sg_r);

  always_comb begin
    if (is_sw) begin
      feb29_nxt = (yg_r[1:0] == 2'd0) && (lg_r || !cnq_g_r);
    end else if (!after) begin
      feb29_nxt = (y_r[1:0] == 2'd0);
    end else begin
      feb29_nxt = (y_r[1:0] == 2'd0) && !cnq_y;
    end
    full_mg = month_len(mg_r, feb29_nxt);
    ovf_nxt = is_sw && (6'(full_mg) < dg_sg);
    if (ovf_nxt) begin
      skip_nxt = 5'(dg_sg - 6'(full_mg) - 6'd1);
    end else if (is_nx && (mg_r == MONTH_MAX) && (dg_sg > 6'd32)) begin
      skip_nxt = 5'(dg_sg - 6'd32);
    end else begin
      skip_nxt = 5'd0;
    end
  end

  // weekday of January 1
  logic [7:0]  corr;
  logic [14:0] wsum;
  logic [2:0]  wd_nxt;
  assign corr   = after ? (8'd88 + 8'(qy_r >> 2) - 8'(qy_r)) : 8'd0;
  assign wsum   = 15'(y_r) + ((15'(y_r) + 15'd3) >> 2) + 15'd4 + 15'(corr);
  assign wd_nxt = mod7(wsum[13:0]);

  // month-length operand for the accumulation loop
  logic       mgm;
  logic [4:0] len_k, full_m, mgp1;
  assign mgm    = is_sw_r && (m_r == mg_r);
  assign full_m = month_len(m_r, feb29_r);
  assign mgp1   = 5'(mg_r) + 5'd1;

  always_comb begin
    if (is_sw_r && (k_r == mg_r)) begin
      len_k = ovf_r ? (dg_r - 5'd1) : (month_len(mg_r, feb29_r) - sg_r);
    end else begin
      len_k = month_len(k_r, feb29_r);
    end
  end

  // skip correction for months after the switch
  logic [2:0] skip7, adj7;
  assign skip7 = mod7(14'(skip_r));
  always_comb begin
    if (is_sw_r && (5'(m_r) > mgp1)) begin
      adj7 = (skip7 == 3'd0) ? 3'd0 : (3'd7 - skip7);
    end else if (is_nx_r && (m_r == 4'd1)) begin
      adj7 = skip7;
    end else begin
      adj7 = 3'd0;
    end
  end

  // shared mod-7 adder
  logic [2:0] alu_b, alu_out;
  always_comb begin
    case (state_r)
      S_SUM:   alu_b = mod7(14'(len_k));
      S_ADJ:   alu_b = adj7;
      S_EMIT:  alu_b = 3'd1;
      default: alu_b = 3'd0;
    endcase
  end
  assign alu_out = add7(acc_r, alu_b);

  // emitter setup: first day, last day
  logic [4:0] start_day, end_day;
  always_comb begin
    end_day = (mgm && ovf_r) ? (dg_r - 5'd1) : full_m;
    if (mgm && (dg_r == 5'd1)) begin
      start_day = sg_r + 5'd1;
    end else if ((is_sw_r && (5'(m_r) == mgp1)) || (is_nx_r && (m_r == 4'd1))) begin
      start_day = skip_r + 5'd1;
    end else begin
      start_day = 5'd1;
    end
  end

  // next printed day, jumping over the switch gap
  logic [5:0] next_day;
  logic       last_day;
  always_comb begin
    next_day = 6'(day_r) + 6'd1;
    if (mgm && (next_day == 6'(dg_r))) begin
      next_day = next_day + 6'(sg_r);
    end
    last_day = (next_day > 6'(end_r));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            m_r     <= in_data.month;
            y_r     <= in_data.year;
            yg_r    <= sw.year;
            mg_r    <= sw.month;
            dg_r    <= sw.day;
            state_r <= bad_req ? S_ERR : S_QG;
          end
        end
        S_QG: begin
          qg_r    <= quot;
          state_r <= S_QY;
        end
        S_QY: begin
          qy_r    <= quot;
          sg_r    <= sg_nxt;
          lg_r    <= lg_nxt;
          cnq_g_r <= cnq_g;
          state_r <= S_LEN;
        end
        S_LEN: begin
          is_sw_r <= is_sw;
          is_nx_r <= is_nx;
          feb29_r <= feb29_nxt;
          ovf_r   <= ovf_nxt;
          skip_r  <= skip_nxt;
          acc_r   <= wd_nxt;
          k_r     <= 4'd1;
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (k_r < m_r) begin
            acc_r <= alu_out;
            k_r   <= k_r + 4'd1;
          end else begin
            state_r <= S_ADJ;
          end
        end
        S_ADJ: begin
          acc_r   <= alu_out;
          day_r   <= start_day;
          end_r   <= end_day;
          row_r   <= 3'd0;
          state_r <= (end_day == 5'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (last_day) begin
              state_r <= S_IDLE;
            end else begin
              day_r <= next_day[4:0];
              acc_r <= alu_out;
              if (alu_out == 3'd0) begin
                row_r <= row_r + 3'd1;
              end
            end
          end
        end
        S_ERR: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ports
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT) || (state_r == S_ERR);

  always_comb begin
    out_data = '0;
    if (state_r == S_ERR) begin
      out_data.last  = 1'b1;
      out_data.error = 1'b1;
    end else begin
      out_data.day_number = day_r;
      out_data.row        = row_r;
      out_data.column     = acc_r;
      out_data.last       = last_day;
    end
  end

  // checks
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while request channel open");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.last && (out_data.day_number == 5'd0)))
    else $error("error result not single and empty");

  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) |=> out_valid)
    else $error("day sequence broken before last");

  a_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.error) |-> ((out_data.column <= 3'd6) && (out_data.row <= 3'd5)))
    else $error("cell outside six-row grid");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> !in_stall)
    else $error("request channel not reopened after last transfer");

endmodule
